### hw/rtl/tias_pkg.sv
// Shared constants, codes and types of the tensor index address store.
package tias_pkg;

  // Store geometry; address arithmetic wraps modulo the depth, which is a power of two.
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned MAX_AXES    = 4;
  localparam int unsigned WORD_BITS   = 32;

  localparam int unsigned ADDR_W   = $clog2(STORE_DEPTH);
  localparam int unsigned AX_W     = $clog2(MAX_AXES);
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned NDIM_W   = 3;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PROD_W   = ADDR_W + DIM_W;
  localparam int unsigned SUM_W    = PROD_W + 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_3 = 3'd4;

  localparam logic [NDIM_W-1:0] NUM_DIMS_RST = 3'd1;
  localparam logic [DIM_W-1:0]  DIM_SIZE_RST = 13'd1;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_READ        = 2'd0,
    MODE_WRITE       = 2'd1,
    MODE_CONSTRAIN   = 2'd2,
    MODE_UNCONSTRAIN = 2'd3
  } mode_e;

  // Active tensor shape: axis count already clamped to 1..MAX_AXES
  typedef struct packed {
    logic [NDIM_W-1:0]                axes;
    logic [MAX_AXES-1:0][DIM_W-1:0]   dim;
  } cfg_t;

  // Classified item: count clamped to the axis count, unused indices zeroed
  typedef struct packed {
    mode_e                            mode;
    logic [CNT_W-1:0]                 count;
    logic [MAX_AXES-1:0][IDX_W-1:0]   idx;
    logic [WORD_BITS-1:0]             wdata;
  } cmd_t;

endpackage

### hw/rtl/tias_in_if.sv
// Input item channel of the tensor index address store.
interface tias_in_if;
  import tias_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [CNT_W-1:0]      index_count;
  logic [IDX_W-1:0]      idx_0;
  logic [IDX_W-1:0]      idx_1;
  logic [IDX_W-1:0]      idx_2;
  logic [IDX_W-1:0]      idx_3;
  logic [WORD_BITS-1:0]  write_value;

  modport source (
    output valid, mode, index_count, idx_0, idx_1, idx_2, idx_3, write_value,
    input  ready
  );

  modport sink (
    input  valid, mode, index_count, idx_0, idx_1, idx_2, idx_3, write_value,
    output ready
  );

endinterface

### hw/rtl/tias_out_if.sv
// Result channel of the tensor index address store.
interface tias_out_if;
  import tias_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [WORD_BITS-1:0]  read_value;
  logic [ADDR_W-1:0]     word_address;
  logic                  out_of_range;

  modport source (
    output valid, read_value, word_address, out_of_range,
    input  ready
  );

  modport sink (
    input  valid, read_value, word_address, out_of_range,
    output ready
  );

endinterface

### hw/rtl/tensor_index_address_store.sv
// Top level of the tensor index address store.
//
// Usage: items arrive on in_i (valid/ready, one transfer per item) and each
// item produces exactly one result transfer on out_o, in order. Registers
// num_dims and dim_size_0..3 are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i while the block is idle; indexes beyond the list are ignored.
// An accepted item passes from the command queue to the back, which walks
// F free (unfixed) axes, 0..4; constrain walks all axes in use, unconstrain
// walks none. The back takes one item at a time; the address walk runs one
// axis per cycle through a single 12x13 multiply-add and is followed by the
// store access state and the result load state, which waits for a free
// output register. A two-entry command queue lets the front keep taking
// items while the back works or waits. A result is held in the output
// register until taken; while the receiver stalls the back finishes the next
// item up to its result and then holds, and the queue fills before in_i
// drops ready. Reset clears the shape to one axis of size one, drops any
// constraint and empties the queue; the word store is not cleared.
module tensor_index_address_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tias_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tias_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  tias_in_if.sink                         in_i,
  tias_out_if.source                      out_o
);
  import tias_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic q_full;
  logic q_valid;
  logic pop;

  // Front: hold the configuration, classify and enqueue each transfer
  tias_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .cfg_o       (cfg)
  );

  // Queue: decouple front acceptance from back-end progress
  tias_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_cmd)
  );

  // Back: walk the axes, access the store, register the result
  tias_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_data_i  (head_cmd),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

### hw/rtl/tias_front.sv
// Front end: configuration registers and classification of input items.
module tias_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tias_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tias_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  tias_in_if.sink                         in_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output tias_pkg::cmd_t                  cmd_o,
  output tias_pkg::cfg_t                  cfg_o
);
  import tias_pkg::*;

  logic [NDIM_W-1:0]              num_dims_q;
  logic [MAX_AXES-1:0][DIM_W-1:0] dim_q;
  logic [NDIM_W-1:0]              axes;
  logic [CNT_W-1:0]               count;
  logic [MAX_AXES-1:0][IDX_W-1:0] idx_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= NUM_DIMS_RST;
      dim_q      <= {MAX_AXES{DIM_SIZE_RST}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_DIMS:   num_dims_q <= cfg_wdata_i[NDIM_W-1:0];
        CFG_DIM_SIZE_0: dim_q[0]   <= cfg_wdata_i;
        CFG_DIM_SIZE_1: dim_q[1]   <= cfg_wdata_i;
        CFG_DIM_SIZE_2: dim_q[2]   <= cfg_wdata_i;
        CFG_DIM_SIZE_3: dim_q[3]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the axis count to 1..MAX_AXES
  always_comb begin
    if (num_dims_q == '0) begin
      axes = NDIM_W'(1);
    end else if (num_dims_q > NDIM_W'(MAX_AXES)) begin
      axes = NDIM_W'(MAX_AXES);
    end else begin
      axes = num_dims_q;
    end
  end

  assign cfg_o.axes = axes;
  assign cfg_o.dim  = dim_q;

  assign idx_raw = {in_i.idx_3, in_i.idx_2, in_i.idx_1, in_i.idx_0};

  // Saturate the index count, zero indices beyond it
  always_comb begin
    count = (in_i.index_count > axes) ? axes : in_i.index_count;
    for (int i = 0; i < MAX_AXES; i++) begin
      cmd_o.idx[i] = (CNT_W'(i) < count) ? idx_raw[i] : '0;
    end
    cmd_o.mode  = mode_e'(in_i.mode);
    cmd_o.count = count;
    cmd_o.wdata = in_i.write_value;
  end

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

endmodule

### hw/rtl/tias_queue.sv
// Short command queue between front and back ends.
module tias_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tias_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tias_pkg::cmd_t data_o
);
  import tias_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### hw/rtl/tias_back.sv
// Back end: row-major address walk, word store access and result register.
module tias_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tias_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  input  tias_pkg::cmd_t q_data_i,
  output logic           pop_o,
  tias_out_if.source     out_o
);
  import tias_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ACCESS,
    ST_REPLY
  } state_e;

  state_e              state_q;
  cmd_t                cmd_q;
  logic [NDIM_W-1:0]   fixed_q;
  logic [ADDR_W-1:0]   base_q;
  logic [NDIM_W-1:0]   ax_q;
  logic [NDIM_W-1:0]   pos_q;
  logic [ADDR_W-1:0]   acc_q;
  logic                big_q;
  logic                rd_sel_q;
  logic [ADDR_W-1:0]   addr_q;
  logic                oor_q;
  logic                out_valid_q;
  logic [WORD_BITS-1:0] out_rd_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic                out_oor_q;

  logic [WORD_BITS-1:0] mem [STORE_DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  logic [NDIM_W-1:0]   fixed_eff;
  logic [NDIM_W-1:0]   start_d;
  logic                walk_d;
  logic [DIM_W-1:0]    dim_cur;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    sum;
  logic                big_d;
  logic [ADDR_W:0]     tot;
  logic [ADDR_W-1:0]   acc_addr;
  logic                acc_oor;
  logic                mem_we, mem_re;
  logic                out_free;

  // Stale constraint: never fix more axes than are in use
  assign fixed_eff = (fixed_q > cfg_i.axes) ? cfg_i.axes : fixed_q;

  always_comb begin
    start_d = (q_data_i.mode == MODE_CONSTRAIN) ? '0 : fixed_eff;
    walk_d  = (q_data_i.mode != MODE_UNCONSTRAIN) && (start_d != cfg_i.axes);
  end

  // One Horner step: acc * dim + idx, tracked modulo the depth plus a too-big flag
  assign dim_cur = cfg_i.dim[ax_q[AX_W-1:0]];
  assign prod    = PROD_W'(acc_q) * PROD_W'(dim_cur);
  assign sum     = SUM_W'(prod) + SUM_W'(cmd_q.idx[pos_q[AX_W-1:0]]);
  assign big_d   = (big_q && (dim_cur != '0)) || (sum[SUM_W-1:ADDR_W] != '0);

  always_comb begin
    tot      = {1'b0, base_q} + {1'b0, acc_q};
    acc_addr = tot[ADDR_W-1:0];
    acc_oor  = big_q || tot[ADDR_W];
  end

  assign mem_we   = (state_q == ST_ACCESS) && (cmd_q.mode == MODE_WRITE) && !acc_oor;
  assign mem_re   = (state_q == ST_ACCESS) && (cmd_q.mode == MODE_READ);
  assign pop_o    = (state_q == ST_IDLE) && q_valid_i;
  assign out_free = !out_valid_q || out_o.ready;

  // Word store; no reset, entries are defined once written
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[acc_addr] <= cmd_q.wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[acc_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fixed_q     <= '0;
      base_q      <= '0;
      ax_q        <= '0;
      pos_q       <= '0;
      acc_q       <= '0;
      big_q       <= 1'b0;
      rd_sel_q    <= 1'b0;
      addr_q      <= '0;
      oor_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_rd_q    <= '0;
      out_addr_q  <= '0;
      out_oor_q   <= 1'b0;
    end else begin
      // Drop a taken result; a reply in the same cycle reloads the register instead
      if (out_valid_q && out_o.ready && (state_q != ST_REPLY)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            ax_q    <= start_d;
            pos_q   <= '0;
            acc_q   <= '0;
            big_q   <= 1'b0;
            state_q <= walk_d ? ST_WALK : ST_ACCESS;
          end
        end
        ST_WALK: begin
          acc_q <= sum[ADDR_W-1:0];
          big_q <= big_d;
          ax_q  <= ax_q + 1'b1;
          pos_q <= pos_q + 1'b1;
          if (ax_q + 1'b1 == cfg_i.axes) begin
            state_q <= ST_ACCESS;
          end
        end
        ST_ACCESS: begin
          rd_sel_q <= (cmd_q.mode == MODE_READ) && !acc_oor;
          case (cmd_q.mode)
            MODE_READ: begin
              addr_q   <= acc_addr;
              oor_q    <= acc_oor;
            end
            MODE_WRITE: begin
              addr_q <= acc_addr;
              oor_q  <= acc_oor;
            end
            MODE_CONSTRAIN: begin
              addr_q <= acc_q;
              oor_q  <= big_q;
              if (!big_q) begin
                fixed_q <= cmd_q.count;
                base_q  <= acc_q;
              end
            end
            default: begin
              addr_q  <= '0;
              oor_q   <= 1'b0;
              fixed_q <= '0;
              base_q  <= '0;
            end
          endcase
          state_q <= ST_REPLY;
        end
        ST_REPLY: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_rd_q    <= rd_sel_q ? rdata_q : '0;
            out_addr_q  <= addr_q;
            out_oor_q   <= oor_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.read_value   = out_rd_q;
  assign out_o.word_address = out_addr_q;
  assign out_o.out_of_range = out_oor_q;

endmodule

### bench/tias_result_checker.sv
`timescale 1ns / 100ps
// Result checker: predicts each tensor store outcome and compares it with the block's results.
module tias_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tias_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tias_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  tias_in_if                              in_ch,
  tias_out_if                             out_ch,
  output int                              fail_cnt_o,
  output int                              pending_o,
  output int                              checked_o,
  output int                              flagged_o
);
  import tias_pkg::*;

  typedef struct {
    logic [WORD_BITS-1:0] rdata;
    logic [ADDR_W-1:0]    addr;
    logic                 oor;
  } outcome_t;

  // Shadow copy of the shape registers and the tensor state
  logic [NDIM_W-1:0]    ndims_q;
  logic [DIM_W-1:0]     dim_q [MAX_AXES];
  int unsigned          fixed_q;
  longint unsigned      base_q;
  logic [WORD_BITS-1:0] store_q [STORE_DEPTH];
  outcome_t             outcome_q [$];

  int fails   = 0;
  int waiting = 0;
  int checked = 0;
  int flagged = 0;

  assign fail_cnt_o = fails;
  assign pending_o  = waiting;
  assign checked_o  = checked;
  assign flagged_o  = flagged;

  function automatic int unsigned axes_used();
    if (ndims_q < 1) return 1;
    if (ndims_q > MAX_AXES) return MAX_AXES;
    return 32'(ndims_q);
  endfunction

  // Row-major stride: product of the sizes of all later axes in use
  function automatic longint unsigned axis_stride(input int unsigned axis, input int unsigned n);
    longint unsigned s;
    s = 1;
    for (int unsigned j = axis + 1; j < n; j++) s = s * 64'(dim_q[j]);
    return s;
  endfunction

  function automatic outcome_t tensor_outcome();
    int unsigned          n;
    int unsigned          c;
    int unsigned          k;
    longint unsigned      addr;
    outcome_t             r;
    logic [IDX_W-1:0]     ix [MAX_AXES];
    ix[0]   = in_ch.idx_0;
    ix[1]   = in_ch.idx_1;
    ix[2]   = in_ch.idx_2;
    ix[3]   = in_ch.idx_3;
    n       = axes_used();
    k       = 32'(in_ch.index_count);
    addr    = 0;
    r.rdata = '0;
    r.oor   = 1'b0;
    case (mode_e'(in_ch.mode))
      MODE_READ, MODE_WRITE: begin
        c = (fixed_q > n) ? n : fixed_q;
        if (k > n - c) k = n - c;
        addr = base_q;
        for (int unsigned i = 0; i < k; i++) addr = addr + 64'(ix[i]) * axis_stride(c + i, n);
        if (addr >= 64'(STORE_DEPTH)) begin
          r.oor = 1'b1;
        end else if (mode_e'(in_ch.mode) == MODE_READ) begin
          r.rdata = store_q[addr[ADDR_W-1:0]];
        end else begin
          store_q[addr[ADDR_W-1:0]] = in_ch.write_value;
        end
      end
      MODE_CONSTRAIN: begin
        if (k > n) k = n;
        for (int unsigned i = 0; i < k; i++) addr = addr + 64'(ix[i]) * axis_stride(i, n);
        if (addr >= 64'(STORE_DEPTH)) begin
          r.oor = 1'b1;
        end else begin
          fixed_q = k;
          base_q  = addr;
        end
      end
      default: begin
        fixed_q = 0;
        base_q  = 0;
      end
    endcase
    r.addr = addr[ADDR_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      ndims_q = NUM_DIMS_RST;
      for (int i = 0; i < MAX_AXES; i++) dim_q[i] = DIM_SIZE_RST;
      fixed_q = 0;
      base_q  = 0;
      outcome_q.delete();
      waiting = 0;
    end else begin
      // A result never belongs to an item taken at the same edge, so retire first
      if (out_ch.valid && out_ch.ready) begin
        if (outcome_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result rd=%h addr=%h oor=%b", $time,
                   out_ch.read_value, out_ch.word_address, out_ch.out_of_range);
        end else begin
          want = outcome_q.pop_front();
          checked++;
          if (want.oor) flagged++;
          if (out_ch.read_value !== want.rdata || out_ch.word_address !== want.addr ||
              out_ch.out_of_range !== want.oor) begin
            fails++;
            $display("%0t: mismatch expected rd=%h addr=%h oor=%b, got rd=%h addr=%h oor=%b",
                     $time, want.rdata, want.addr, want.oor, out_ch.read_value,
                     out_ch.word_address, out_ch.out_of_range);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) outcome_q.push_back(tensor_outcome());
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_DIMS:   ndims_q  = cfg_wdata_i[NDIM_W-1:0];
          CFG_DIM_SIZE_0: dim_q[0] = cfg_wdata_i;
          CFG_DIM_SIZE_1: dim_q[1] = cfg_wdata_i;
          CFG_DIM_SIZE_2: dim_q[2] = cfg_wdata_i;
          CFG_DIM_SIZE_3: dim_q[3] = cfg_wdata_i;
          default: ;
        endcase
      end
      waiting = outcome_q.size();
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Top of the tensor index address store testbench: clock, reset, stimulus and verdict.
module tb;
  import tias_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 140;
  localparam int unsigned HOLD_PHASE    = 3;
  localparam int unsigned TAIL_CYCLES   = 20;

  typedef struct {
    mode_e                          mode;
    logic [CNT_W-1:0]               count;
    logic [MAX_AXES-1:0][IDX_W-1:0] idx;
    logic [WORD_BITS-1:0]           wval;
  } item_t;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tias_in_if  in_ch ();
  tias_out_if out_ch ();

  int fail_cnt;
  int pending;
  int checked;
  int flagged;

  // Current shape as written, used only to steer indices toward valid addresses
  int unsigned shp_nd;
  int unsigned shp_dim [MAX_AXES];
  int unsigned shapes = 0;

  // Constraint state and written words as the stimulus sees them; reads of
  // words never written are turned into writes
  int unsigned     stim_fixed = 0;
  longint unsigned stim_base  = 0;
  bit              stim_written [STORE_DEPTH];

  // Sender burst state
  bit          gaps_on    = 1'b1;
  int unsigned burst_left = 0;
  int unsigned mode_cnt [4] = '{default: 0};

  // Long receiver hold-off: the main process requests, the receiver serves
  int unsigned hold_req  = 0;
  int unsigned hold_done = 0;

  longint unsigned cycle_cnt = 0;

  tensor_index_address_store dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  tias_result_checker res_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .checked_o   (checked),
    .flagged_o   (flagged)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: end the run if it hangs
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: switch stall style every so often; serve long hold-offs on request
  initial begin : receiver
    int unsigned style;
    int unsigned span;
    out_ch.ready = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(16, 200);
      repeat (span) begin
        @(negedge clk_i);
        if (hold_req != hold_done) begin
          // Hold off long enough for the queue to fill and in_i to stall
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          hold_done++;
        end
        case (style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic item_t item_of(input mode_e m, input int unsigned cnt,
                                    input int unsigned i0, input int unsigned i1,
                                    input int unsigned i2, input int unsigned i3,
                                    input logic [WORD_BITS-1:0] w);
    item_t it;
    it.mode   = m;
    it.count  = CNT_W'(cnt);
    it.idx[0] = IDX_W'(i0);
    it.idx[1] = IDX_W'(i1);
    it.idx[2] = IDX_W'(i2);
    it.idx[3] = IDX_W'(i3);
    it.wval   = w;
    return it;
  endfunction

  function automatic int unsigned used_axes();
    if (shp_nd < 1) return 1;
    if (shp_nd > MAX_AXES) return MAX_AXES;
    return shp_nd;
  endfunction

  // Index bound that keeps an axis inside its size (zero and oversize clamped)
  function automatic int unsigned axis_lim(input int unsigned axis);
    if (shp_dim[axis] == 0) return 1;
    if (shp_dim[axis] > STORE_DEPTH) return STORE_DEPTH;
    return shp_dim[axis];
  endfunction

  function automatic longint unsigned stim_stride(input int unsigned axis, input int unsigned n);
    longint unsigned s;
    s = 1;
    for (int unsigned j = axis + 1; j < n; j++) s = s * 64'(shp_dim[j]);
    return s;
  endfunction

  // Track the constraint and the written words; turn a read of a fresh word into a write
  function automatic item_t steer_item(input item_t it);
    item_t           s;
    int unsigned     n;
    int unsigned     c;
    int unsigned     k;
    longint unsigned addr;
    s    = it;
    n    = used_axes();
    k    = 32'(it.count);
    addr = 0;
    case (it.mode)
      MODE_READ, MODE_WRITE: begin
        c = (stim_fixed > n) ? n : stim_fixed;
        if (k > n - c) k = n - c;
        addr = stim_base;
        for (int unsigned i = 0; i < k; i++) begin
          addr = addr + 64'(it.idx[i]) * stim_stride(c + i, n);
        end
        if (addr < 64'(STORE_DEPTH)) begin
          if (!stim_written[addr[ADDR_W-1:0]]) s.mode = MODE_WRITE;
          if (s.mode == MODE_WRITE) stim_written[addr[ADDR_W-1:0]] = 1'b1;
        end
      end
      MODE_CONSTRAIN: begin
        if (k > n) k = n;
        for (int unsigned i = 0; i < k; i++) begin
          addr = addr + 64'(it.idx[i]) * stim_stride(i, n);
        end
        if (addr < 64'(STORE_DEPTH)) begin
          stim_fixed = k;
          stim_base  = addr;
        end
      end
      default: begin
        stim_fixed = 0;
        stim_base  = 0;
      end
    endcase
    return s;
  endfunction

  function automatic int unsigned rand_axes();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, MAX_AXES);
    return $urandom_range(0, 7);
  endfunction

  function automatic int unsigned rand_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 16);
    if (r < 78) return 0;
    if (r < 90) return $urandom_range(17, STORE_DEPTH);
    return $urandom_range(0, 8191);
  endfunction

  // Mostly in-bounds accesses and constraints with random content, some noise
  function automatic item_t random_item();
    item_t       it;
    int unsigned r;
    int unsigned n;
    int unsigned lim;
    n   = used_axes();
    lim = STORE_DEPTH;
    for (int unsigned a = 0; a < n; a++) if (axis_lim(a) < lim) lim = axis_lim(a);
    r = $urandom_range(0, 99);
    if (r < 40)      it.mode = MODE_READ;
    else if (r < 75) it.mode = MODE_WRITE;
    else if (r < 88) it.mode = MODE_CONSTRAIN;
    else             it.mode = MODE_UNCONSTRAIN;
    r = $urandom_range(0, 99);
    if (r < 70)      it.count = CNT_W'((it.mode == MODE_CONSTRAIN) ? $urandom_range(0, n) : n);
    else if (r < 85) it.count = CNT_W'($urandom_range(0, 4));
    else             it.count = CNT_W'($urandom_range(0, 7));
    for (int unsigned a = 0; a < MAX_AXES; a++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        it.idx[a] = IDX_W'($urandom);
      end else if (it.mode == MODE_CONSTRAIN || r < 30) begin
        it.idx[a] = IDX_W'($urandom_range(0, axis_lim(a) - 1));
      end else begin
        it.idx[a] = IDX_W'($urandom_range(0, lim - 1));
      end
    end
    it.wval = $urandom;
    return it;
  endfunction

  // Offer one item, with a gap between bursts; return once it is transferred
  task automatic send_item(input item_t it);
    int unsigned gap;
    item_t       s;
    gap = 0;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    s = steer_item(it);
    @(negedge clk_i);
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= s.mode;
    in_ch.index_count <= s.count;
    in_ch.idx_0       <= s.idx[0];
    in_ch.idx_1       <= s.idx[1];
    in_ch.idx_2       <= s.idx[2];
    in_ch.idx_3       <= s.idx[3];
    in_ch.write_value <= s.wval;
    do @(posedge clk_i); while (!in_ch.ready);
    mode_cnt[s.mode]++;
  endtask

  // Drop valid and hold until every expected result has been transferred
  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Reshape only while idle; every register is rewritten each time
  task automatic set_shape(input int unsigned nd, input int unsigned d0, input int unsigned d1,
                           input int unsigned d2, input int unsigned d3);
    wait_idle();
    shp_nd     = nd;
    shp_dim[0] = d0;
    shp_dim[1] = d1;
    shp_dim[2] = d2;
    shp_dim[3] = d3;
    write_reg(CFG_NUM_DIMS, nd);
    write_reg(CFG_DIM_SIZE_0, d0);
    write_reg(CFG_DIM_SIZE_1, d1);
    write_reg(CFG_DIM_SIZE_2, d2);
    write_reg(CFG_DIM_SIZE_3, d3);
    shapes++;
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.mode        = '0;
    in_ch.index_count = '0;
    in_ch.idx_0       = '0;
    in_ch.idx_1       = '0;
    in_ch.idx_2       = '0;
    in_ch.idx_3       = '0;
    in_ch.write_value = '0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_wdata         = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: a full 8x8x8x8 tensor
    set_shape(4, 8, 8, 8, 8);
    send_item(item_of(MODE_WRITE, 4, 7, 7, 7, 7, 32'hFFFF_FFFF));    // last word
    send_item(item_of(MODE_READ, 4, 7, 7, 7, 7, 32'h0));
    send_item(item_of(MODE_WRITE, 0, 5, 5, 5, 5, 32'h0));            // no indices: word zero
    send_item(item_of(MODE_READ, 0, 1, 1, 1, 1, 32'h0));
    send_item(item_of(MODE_READ, 7, 1, 2, 3, 4, 32'h0));             // count saturates
    send_item(item_of(MODE_READ, 1, 4095, 0, 0, 0, 32'h0));          // beyond the store
    send_item(item_of(MODE_WRITE, 4, 4095, 4095, 4095, 4095, 32'hAAAA_5555)); // dropped
    send_item(item_of(MODE_CONSTRAIN, 2, 1, 2, 0, 0, 32'h0));
    send_item(item_of(MODE_WRITE, 2, 3, 4, 0, 0, 32'h1234_5678));
    send_item(item_of(MODE_READ, 7, 3, 4, 4095, 4095, 32'h0));
    send_item(item_of(MODE_CONSTRAIN, 1, 5, 0, 0, 0, 32'h0));        // replaces the old one
    send_item(item_of(MODE_READ, 3, 1, 1, 1, 0, 32'h0));
    send_item(item_of(MODE_CONSTRAIN, 7, 4095, 4095, 4095, 4095, 32'h0)); // base too far
    send_item(item_of(MODE_READ, 3, 0, 0, 0, 0, 32'h0));
    send_item(item_of(MODE_CONSTRAIN, 3, 2, 3, 4, 0, 32'h0));
    // Lower the axis count below the fixed count: stale constraint
    set_shape(1, STORE_DEPTH, 8, 8, 8);
    send_item(item_of(MODE_READ, 2, 9, 9, 0, 0, 32'h0));
    send_item(item_of(MODE_UNCONSTRAIN, 4, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF));
    send_item(item_of(MODE_READ, 1, 4095, 0, 0, 0, 32'h0));
    // Axis count above the maximum, zero-size axes giving zero strides
    set_shape(7, 0, STORE_DEPTH, 0, 16);
    send_item(item_of(MODE_WRITE, 4, 4095, 4095, 5, 3, 32'h5A5A_A5A5));
    send_item(item_of(MODE_READ, 4, 1, 2, 5, 3, 32'h0));
    send_item(item_of(MODE_CONSTRAIN, 4, 100, 200, 255, 15, 32'h0)); // every axis fixed
    send_item(item_of(MODE_READ, 4, 1, 1, 1, 1, 32'h0));
    send_item(item_of(MODE_UNCONSTRAIN, 0, 0, 0, 0, 0, 32'h0));
    // Axis count zero acts as one; oversize axis field
    set_shape(0, 8191, 0, 0, 0);
    send_item(item_of(MODE_READ, 1, 4095, 0, 0, 0, 32'h0));
    send_item(item_of(MODE_WRITE, 1, 0, 0, 0, 0, 32'h0));

    // Random phases: extremes first, then random shapes
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       set_shape(4, STORE_DEPTH, STORE_DEPTH, STORE_DEPTH, STORE_DEPTH);
        1:       set_shape(1, 1, 1, 1, 1);
        2:       set_shape(3, 16, 16, 16, 8191);
        default: set_shape(rand_axes(), rand_dim(), rand_dim(), rand_dim(), rand_dim());
      endcase
      gaps_on    = (p % 3 != 1) && (p != HOLD_PHASE);
      burst_left = 0;
      if (p == HOLD_PHASE) hold_req++;
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        // Now and then pause the sender until the block has drained
        if ($urandom_range(0, 99) == 0) wait_idle();
        send_item(random_item());
      end
    end

    // Drain, then keep the clock running for any stray result
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d reads, %0d writes, %0d constrains, %0d unconstrains over %0d shapes",
             mode_cnt[MODE_READ], mode_cnt[MODE_WRITE], mode_cnt[MODE_CONSTRAIN],
             mode_cnt[MODE_UNCONSTRAIN], shapes);
    $display("Checked %0d results, %0d flagged out of range, %0d mismatches",
             checked, flagged, fail_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
